### rtl/igp_pkg.sv
// ----------------------------------------------------------------------------
// igp_pkg - interval gain partition shared definitions
// sizes, register map and sequencer states of the interval selection block
// ----------------------------------------------------------------------------
package igp_pkg;

  localparam int MAX_HORIZON = 64;
  localparam int HZ_W        = $clog2(MAX_HORIZON + 2);
  localparam int TBL_DEPTH   = MAX_HORIZON * MAX_HORIZON;
  localparam int TBL_AW      = $clog2(TBL_DEPTH);
  localparam int CNT_W       = $clog2(TBL_DEPTH + 1);
  localparam int BEST_DEPTH  = MAX_HORIZON + 2;
  localparam int BEST_AW     = $clog2(BEST_DEPTH);
  localparam int GAIN_W      = 16;
  localparam int TOTAL_W     = 21;
  localparam int CFG_DW      = 32;
  localparam int CFG_AW      = 3;
  localparam int CFG_REG_W   = 7;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [CFG_REG_W-1:0] HORIZON_RST = 7'd64;

  // register index (word address bit)
  localparam logic REG_HORIZON = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_ACC,
    S_WRITE
  } igp_state_t;

endpackage

### rtl/interval_gain_partition_dp.sv
// ----------------------------------------------------------------------------
// interval_gain_partition_dp - weighted interval selection with gap
// loads a gain table word by word, then runs a prefix dp on one shared
// saturating add / compare unit and reports the best total gain
// ----------------------------------------------------------------------------
// usage
//   input channel: a word (in_gain, in_last) is taken at a clock edge where
//   start is high and busy is low. words fill the horizon x horizon gain
//   table in row-major order, one per cycle; words past the table end are
//   dropped. the word with in_last set is stored, then the dp walk starts.
//   result channel: out_best_total is shown for one cycle with out_valid.
//   the receiver cannot stall, so the result is never held.
//   busy stays high for the whole walk after the last word (h = horizon,
//   capped at 64), and out_valid rises in the same cycle that busy falls;
//   with h = 0 the zero result is given without a walk and busy never rises.
//   each (t, i) step of the walk spends a read state on the registered reads
//   of the gain table and best-prefix memories, then an accumulate state on
//   the shared add, saturate and compare; each t ends in a write of best[t].
//   config: apb register 0 (byte address 0) is horizon, reset 64; write it
//   only while busy is low.
//   reset: synchronous, active low; clears the sequencer, the load count,
//   the output strobe and sets horizon to 64. the table is not cleared.
// ----------------------------------------------------------------------------
module interval_gain_partition_dp
  import igp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  logic [GAIN_W-1:0]  in_gain,
  input  logic               in_last,
  // result channel
  output logic               out_valid,
  output logic [TOTAL_W-1:0] out_best_total,
  // apb configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [CFG_AW-1:0]  paddr,
  input  logic [CFG_DW-1:0]  pwdata,
  output logic [CFG_DW-1:0]  prdata,
  output logic               pready
);

  // --------------------------------------------------------------------------
  // configuration register
  // --------------------------------------------------------------------------
  logic [CFG_REG_W-1:0] horizon_r;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_HORIZON);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horizon_r <= HORIZON_RST;
    end else if (cfg_wr) begin
      horizon_r <= pwdata[CFG_REG_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_HORIZON) begin
      prdata = {{(CFG_DW-CFG_REG_W){1'b0}}, horizon_r};
    end else begin
      prdata = '0;
    end
  end

  // effective horizon, capped at the table size
  logic [HZ_W-1:0]  h_eff;
  logic [CNT_W-1:0] cap;

  assign h_eff = (horizon_r > CFG_REG_W'(MAX_HORIZON)) ? HZ_W'(MAX_HORIZON)
                                                       : HZ_W'(horizon_r);
  assign cap   = CNT_W'(h_eff) * CNT_W'(h_eff);

  // --------------------------------------------------------------------------
  // sequencer state and datapath registers
  // --------------------------------------------------------------------------
  igp_state_t          state_r, state_nxt;
  logic [CNT_W-1:0]    load_cnt_r, load_cnt_nxt;
  logic [HZ_W-1:0]     h_r, h_nxt;           // horizon latched for the walk
  logic [HZ_W-1:0]     t_r, t_nxt;           // prefix being computed
  logic [HZ_W-1:0]     i_r, i_nxt;           // split point
  logic [TBL_AW-1:0]   addr_r, addr_nxt;     // i*h + t-2, stepped by h
  logic [TOTAL_W-1:0]  cur_r, cur_nxt;       // running max, best[t-1] on entry
  logic                out_valid_r, out_valid_nxt;
  logic [TOTAL_W-1:0]  out_total_r, out_total_nxt;

  logic                accept;
  logic                tbl_we;

  // memory read registers
  logic [GAIN_W-1:0]   gain_rd_r;
  logic [TOTAL_W-1:0]  best_rd_r;
  logic                i_low_r;              // best[0] and best[1] are zero

  // shared add / saturate / compare unit
  logic [TOTAL_W-1:0]  best_sel;
  logic [TOTAL_W:0]    sum_w;
  logic [TOTAL_W-1:0]  sum_sat;
  logic                sum_gt;

  assign accept = start && !busy;
  assign tbl_we = accept && (load_cnt_r < cap);

  assign best_sel = i_low_r ? '0 : best_rd_r;
  assign sum_w    = {1'b0, best_sel} + (TOTAL_W+1)'(gain_rd_r);
  assign sum_sat  = sum_w[TOTAL_W] ? TOTAL_MAX : sum_w[TOTAL_W-1:0];
  assign sum_gt   = sum_sat > cur_r;

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_best_total = out_total_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_last && (h_eff != '0)) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        if (i_r == t_r - HZ_W'(2)) begin
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_WRITE: begin
        if (t_r == h_r + HZ_W'(1)) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    load_cnt_nxt  = load_cnt_r;
    h_nxt         = h_r;
    t_nxt         = t_r;
    i_nxt         = i_r;
    addr_nxt      = addr_r;
    cur_nxt       = cur_r;
    out_valid_nxt = 1'b0;
    out_total_nxt = out_total_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (tbl_we) begin
            load_cnt_nxt = load_cnt_r + CNT_W'(1);
          end
          if (in_last) begin
            load_cnt_nxt = '0;
            h_nxt        = h_eff;
            t_nxt        = HZ_W'(2);
            i_nxt        = '0;
            addr_nxt     = '0;
            cur_nxt      = '0;
            if (h_eff == '0) begin
              // no periods: result is best[1]
              out_valid_nxt = 1'b1;
              out_total_nxt = '0;
            end
          end
        end
      end
      S_READ: begin
      end
      S_ACC: begin
        if (sum_gt) begin
          cur_nxt = sum_sat;
        end
        if (i_r != t_r - HZ_W'(2)) begin
          i_nxt    = i_r + HZ_W'(1);
          addr_nxt = addr_r + TBL_AW'(h_r);
        end
      end
      S_WRITE: begin
        if (t_r == h_r + HZ_W'(1)) begin
          out_valid_nxt = 1'b1;
          out_total_nxt = cur_r;
        end else begin
          // best[t+1] starts from best[t], first column is t-1
          t_nxt    = t_r + HZ_W'(1);
          i_nxt    = '0;
          addr_nxt = TBL_AW'(t_r - HZ_W'(1));
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      load_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    h_r         <= h_nxt;
    t_r         <= t_nxt;
    i_r         <= i_nxt;
    addr_r      <= addr_nxt;
    cur_r       <= cur_nxt;
    out_total_r <= out_total_nxt;
    i_low_r     <= (i_r < HZ_W'(2));
  end

  // --------------------------------------------------------------------------
  // gain table: one write port for loading, one registered read for the walk
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0] gain_mem [TBL_DEPTH];

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      gain_mem[load_cnt_r[TBL_AW-1:0]] <= in_gain;
    end
    gain_rd_r <= gain_mem[addr_r];
  end

  // --------------------------------------------------------------------------
  // best-prefix store: best[t] written once per t, read at the split point
  // --------------------------------------------------------------------------
  logic [TOTAL_W-1:0] best_mem [BEST_DEPTH];

  always_ff @(posedge clk) begin
    if (state_r == S_WRITE) begin
      best_mem[t_r[BEST_AW-1:0]] <= cur_r;
    end
    best_rd_r <= best_mem[i_r[BEST_AW-1:0]];
  end

`ifndef SYNTHESIS
  // a result appears only once the walk has returned to idle
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // every accumulate step consumes a read issued the cycle before
  a_acc_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> ($past(state_r) == S_READ))
    else $error("accumulate without a preceding read");

  // split point stays below the prefix being computed
  a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> ((i_r + HZ_W'(2)) <= t_r))
    else $error("split point out of range");

  // running max never falls during a walk
  a_cur_mono: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r != S_IDLE) && ($past(state_r) != S_IDLE)) |-> (cur_r >= $past(cur_r)))
    else $error("running max decreased");
`endif

endmodule
